>>> rtl/pif_pkg.sv
// pif_pkg: types and constants shared by the pick id majority finder
// depends on nothing; used by pif_front, pif_back and the top level
package pif_pkg;

  localparam int KEY_W             = 32;
  localparam int BYTE_W            = 8;
  localparam int COUNT_W           = 13;
  localparam int COUNT_FIELD_MAX   = 8191;
  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_MAX_PIXELS    = 4096;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] alpha_byte;
    logic              frame_end;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   winner_id;
    logic [COUNT_W-1:0] winner_count;
    logic               table_overflow;
  } out_word_t;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } item_t;

endpackage

>>> rtl/pick_id_majority_finder_core.sv
// pick_id_majority_finder_core: top level of the most frequent pick id finder
// depends on pif_pkg, pif_front and pif_back
//
//   channel  | ports                         | word
//   ---------+-------------------------------+--------------------------------
//   pixels   | push, full, in_word           | four id bytes and frame_end
//   result   | empty, pop, out_word          | winner id, count, overflow flag
//
// a pixel waits in a four deep queue, then the back end scans the key table one
// entry at a time, a registered memory read in one state and a compare in the
// next; a hit ends the scan, a new key is written after the last used entry
// the frame's last pixel then passes through an emit state to load the result register
// reset (rst_n, synchronous) empties queue, table and result; the table needs no
// clearing pass, its fill count alone marks which entries hold keys
// the back end stalls on a full result register only at frame end
module pick_id_majority_finder_core #(
  parameter int TABLE_ENTRIES = pif_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_PIXELS    = pif_pkg::DEF_MAX_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  pif_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output pif_pkg::out_word_t out_word
);

  logic           q_valid;
  logic           q_pop;
  pif_pkg::item_t q_item;

  pif_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  pif_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_PIXELS    (MAX_PIXELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

>>> rtl/pif_front.sv
// pif_front: accepts pixel words, builds the 32-bit key and queues it
// depends on pif_pkg
module pif_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  pif_pkg::in_word_t in_word,
  output logic              q_valid,
  input  logic              q_pop,
  output pif_pkg::item_t    q_item
);

  pif_pkg::item_t                   q_mem_r [pif_pkg::QUEUE_DEPTH];
  logic [pif_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pif_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [pif_pkg::QUEUE_CNT_W-1:0]  fill_r, fill_nxt;
  logic                             do_push, do_pop;
  pif_pkg::item_t                   new_item;

  assign full    = (fill_r == pif_pkg::QUEUE_CNT_W'(pif_pkg::QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // red is the low byte, alpha the high byte
  assign new_item.key  = {in_word.alpha_byte, in_word.blue_byte,
                          in_word.green_byte, in_word.red_byte};
  assign new_item.last = in_word.frame_end;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pif_pkg::QUEUE_PTR_W'(pif_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + pif_pkg::QUEUE_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pif_pkg::QUEUE_PTR_W'(pif_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + pif_pkg::QUEUE_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + pif_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - pif_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= pif_pkg::QUEUE_CNT_W'(pif_pkg::QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (fill_r == $past(fill_r) + pif_pkg::QUEUE_CNT_W'(1)))
    else $error("queue fill did not follow a lone write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

>>> rtl/pif_back.sv
// pif_back: key table search, count update, running best and result register
// depends on pif_pkg; key and count tables are single-port-read memories
module pif_back #(
  parameter int TABLE_ENTRIES = pif_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_PIXELS    = pif_pkg::DEF_MAX_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  pif_pkg::item_t     q_item,
  output logic               empty,
  input  logic               pop,
  output pif_pkg::out_word_t out_word
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [pif_pkg::COUNT_W-1:0] COUNT_CAP =
    pif_pkg::COUNT_W'((MAX_PIXELS < pif_pkg::COUNT_FIELD_MAX) ?
                      MAX_PIXELS : pif_pkg::COUNT_FIELD_MAX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [pif_pkg::KEY_W-1:0]   key_mem [TABLE_ENTRIES];
  logic [pif_pkg::COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];

  logic [1:0]                  state_r, state_nxt;
  logic [USED_W-1:0]           idx_r, idx_nxt;
  logic [USED_W-1:0]           used_r, used_nxt;
  logic [pif_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic                        last_r, last_nxt;
  logic [pif_pkg::KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [pif_pkg::COUNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pif_pkg::out_word_t          out_word_r, out_word_nxt;

  logic [pif_pkg::KEY_W-1:0]   rd_key_r;
  logic [pif_pkg::COUNT_W-1:0] rd_cnt_r;

  logic                        rd_en, key_wr, cnt_wr;
  logic [IDX_W-1:0]            rd_addr, wr_addr;
  logic [pif_pkg::COUNT_W-1:0] cnt_wdata;
  logic                        offer;
  logic [pif_pkg::COUNT_W-1:0] offer_cnt;
  logic                        take_best;
  logic                        out_free;

  assign empty    = !out_valid_r;
  assign out_word = out_word_r;
  assign out_free = !out_valid_r || pop;

  // smaller key wins on equal counts
  assign take_best = (offer_cnt > best_cnt_r) ||
                     ((offer_cnt == best_cnt_r) && (key_r < best_key_r));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    best_key_nxt  = best_key_r;
    best_cnt_nxt  = best_cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !pop;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    key_wr        = 1'b0;
    cnt_wr        = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    cnt_wdata     = rd_cnt_r;
    offer         = 1'b0;
    offer_cnt     = rd_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          key_nxt   = q_item.key;
          last_nxt  = q_item.last;
          idx_nxt   = '0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (idx_r == used_r) begin
          // miss: new entry or drop
          if (used_r != USED_W'(TABLE_ENTRIES)) begin
            key_wr    = 1'b1;
            cnt_wr    = 1'b1;
            wr_addr   = used_r[IDX_W-1:0];
            cnt_wdata = pif_pkg::COUNT_W'(1);
            used_nxt  = used_r + USED_W'(1);
            offer     = 1'b1;
            offer_cnt = pif_pkg::COUNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_key_r == key_r) begin
          cnt_wdata = (rd_cnt_r < COUNT_CAP) ? rd_cnt_r + pif_pkg::COUNT_W'(1) : rd_cnt_r;
          cnt_wr    = 1'b1;
          offer     = 1'b1;
          offer_cnt = cnt_wdata;
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + USED_W'(1);
          state_nxt = ST_LOOK;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.winner_id      = best_key_r;
          out_word_nxt.winner_count   = best_cnt_r;
          out_word_nxt.table_overflow = ovf_r;
          used_nxt                    = '0;
          best_key_nxt                = '0;
          best_cnt_nxt                = '0;
          ovf_nxt                     = 1'b0;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (offer && take_best) begin
      best_key_nxt = key_r;
      best_cnt_nxt = offer_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      best_key_r  <= '0;
      best_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      best_key_r  <= best_key_nxt;
      best_cnt_r  <= best_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  // table memories, registered read
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      rd_cnt_r <= cnt_mem[rd_addr];
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_ENTRIES))
    else $error("table fill above capacity");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (idx_r < used_r))
    else $error("compare on an unwritten entry");

  a_best_cap: assert property (@(posedge clk) disable iff (!rst_n)
    best_cnt_r <= COUNT_CAP)
    else $error("best count above cap");

  a_best_vs_used: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) == (best_cnt_r == '0))
    else $error("best count out of step with table fill");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (used_r == '0 && !ovf_r && out_valid_r))
    else $error("frame not cleared after result");

endmodule

>>> sim/pif_checker.sv
// pif_checker: watches the pixel and result queues of the pick id majority finder,
// keeps its own key tally per frame and compares every popped result word
// depends on pif_pkg for the word types and table limits
module pif_checker #(
  parameter int TABLE_ENTRIES = pif_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_PIXELS    = pif_pkg::DEF_MAX_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  pif_pkg::in_word_t  in_word,
  input  logic               empty,
  input  logic               pop,
  input  pif_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIT_CAP = (MAX_PIXELS < pif_pkg::COUNT_FIELD_MAX) ?
                           MAX_PIXELS : pif_pkg::COUNT_FIELD_MAX;

  logic [pif_pkg::KEY_W-1:0]   tally_key  [TABLE_ENTRIES];
  logic [pif_pkg::COUNT_W-1:0] tally_hits [TABLE_ENTRIES];
  int                          tally_used;
  logic [pif_pkg::KEY_W-1:0]   lead_key;
  logic [pif_pkg::COUNT_W-1:0] lead_hits;
  logic                        keys_dropped;
  pif_pkg::out_word_t          winners_due[$];
  int                          errors = 0;

  assign fail_count = errors;

  function automatic void clear_tally();
    tally_used   = 0;
    lead_key     = '0;
    lead_hits    = '0;
    keys_dropped = 1'b0;
  endfunction

  function automatic void offer_lead(logic [pif_pkg::KEY_W-1:0] key,
                                     logic [pif_pkg::COUNT_W-1:0] hits);
    if (hits > lead_hits || (hits == lead_hits && key < lead_key)) begin
      lead_key  = key;
      lead_hits = hits;
    end
  endfunction

  // count one pixel; on frame end queue the winner word and start a fresh frame
  function automatic void tally_pixel(pif_pkg::in_word_t w);
    logic [pif_pkg::KEY_W-1:0] key;
    int                        slot;
    pif_pkg::out_word_t        win;
    key  = {w.alpha_byte, w.blue_byte, w.green_byte, w.red_byte};
    slot = -1;
    for (int i = 0; i < tally_used; i++) begin
      if (slot < 0 && tally_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      if (tally_hits[slot] < HIT_CAP)
        tally_hits[slot] = tally_hits[slot] + pif_pkg::COUNT_W'(1);
      offer_lead(key, tally_hits[slot]);
    end else if (tally_used < TABLE_ENTRIES) begin
      tally_key[tally_used]  = key;
      tally_hits[tally_used] = pif_pkg::COUNT_W'(1);
      tally_used++;
      offer_lead(key, pif_pkg::COUNT_W'(1));
    end else begin
      keys_dropped = 1'b1;
    end
    if (w.frame_end) begin
      win.winner_id      = lead_key;
      win.winner_count   = lead_hits;
      win.table_overflow = keys_dropped;
      winners_due.push_back(win);
      clear_tally();
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  always @(posedge clk) begin
    pif_pkg::out_word_t want;
    if (!rst_n) begin
      clear_tally();
      winners_due.delete();
    end else begin
      if (pop && !empty) begin
        if (winners_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_word);
        end else begin
          want = winners_due.pop_front();
          if (out_word.winner_id !== want.winner_id)
            flag_mismatch("winner_id", want.winner_id, out_word.winner_id);
          if (out_word.winner_count !== want.winner_count)
            flag_mismatch("winner_count", 32'(want.winner_count),
                          32'(out_word.winner_count));
          if (out_word.table_overflow !== want.table_overflow)
            flag_mismatch("table_overflow", 32'(want.table_overflow),
                          32'(out_word.table_overflow));
        end
      end
      if (push && !full) tally_pixel(in_word);
    end
    results_pending <= winners_due.size();
  end

endmodule

>>> sim/pick_id_majority_finder_core_tb.sv
// pick_id_majority_finder_core_tb: drives pixel frames into the finder and pops results
// at random pace; pif_checker does the prediction and comparison
// depends on pif_pkg, pif_checker and the pick_id_majority_finder_core rtl
module pick_id_majority_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PIXEL_TARGET = 470;
  localparam int TIE_RUN      = 40;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  pif_pkg::in_word_t  pix_word;
  logic               empty;
  logic               pop;
  pif_pkg::out_word_t result_word;
  int                 fail_count;
  int                 results_pending;

  logic [pif_pkg::KEY_W-1:0] frame_keys[$];
  int                        pixels_sent = 0;
  logic                      no_idle = 1'b0;
  int                        overflow_frames = 0;
  int                        idle_cycles = 0;

  pick_id_majority_finder_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (pix_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (result_word)
  );

  pif_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_word         (pix_word),
    .empty           (empty),
    .pop             (pop),
    .out_word        (result_word),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ends the run when no word moves on either side for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [pif_pkg::KEY_W-1:0] key, logic last);
    int gap;
    pif_pkg::in_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.red_byte   = key[7:0];
    w.green_byte = key[15:8];
    w.blue_byte  = key[23:16];
    w.alpha_byte = key[31:24];
    w.frame_end  = last;
    push     <= 1'b1;
    pix_word <= w;
    do @(posedge clk); while (full);
    pixels_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_keys[i]) send_pixel(frame_keys[i], i == frame_keys.size() - 1);
    frame_keys.delete();
  endtask

  task automatic wait_results_drained();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // distinct keys, low byte carries the index; repeats land on randomly chosen entries
  task automatic build_wide_frame(int distinct, int repeats);
    logic [pif_pkg::KEY_W-1:0] k;
    for (int i = 0; i < distinct; i++) begin
      k = $urandom();
      frame_keys.push_back({k[31:8], i[7:0]});
    end
    for (int i = 0; i < repeats; i++)
      frame_keys.push_back(frame_keys[$urandom_range(0, distinct - 1)]);
  endtask

  task automatic build_pool_frame();
    logic [pif_pkg::KEY_W-1:0] pool[6];
    logic [pif_pkg::KEY_W-1:0] base;
    int pool_n, len, pick;
    pool_n = $urandom_range(1, 6);
    len    = $urandom_range(1, 24);
    base   = $urandom();
    for (int i = 0; i < pool_n; i++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) pool[i] = '0;
      else if (pick == 1) pool[i] = '1;
      // neighbors of one base key stress the smaller-key tie rule
      else if (pick < 5) pool[i] = base ^ (32'h1 << $urandom_range(0, 31));
      else pool[i] = $urandom();
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) frame_keys.push_back($urandom());
      else frame_keys.push_back(pool[$urandom_range(0, pool_n - 1)]);
    end
  endtask

  // receiver side
  initial begin
    int n;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    logic [pif_pkg::KEY_W-1:0] key_hi, key_lo;
    int kind;
    rst_n    <= 1'b0;
    push     <= 1'b0;
    pix_word <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames: background alone, all ones alone, ties both ways, overtaking
    frame_keys = '{32'h0};                                   send_frame();
    frame_keys = '{32'hFFFF_FFFF};                           send_frame();
    frame_keys = '{32'h5, 32'h3};                            send_frame();
    frame_keys = '{32'h3, 32'h5};                            send_frame();
    frame_keys = '{32'h7, 32'h0, 32'h7, 32'h0};              send_frame();
    frame_keys = '{32'h8000_0000, 32'h1234_5678, 32'h1234_5678, 32'h8000_0000,
                   32'hAA55_AA55, 32'hAA55_AA55, 32'hAA55_AA55};
    send_frame();
    frame_keys = '{32'h0102_0304, 32'h0102_0304, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF};
    send_frame();

    // table filled exactly, last entry hit again
    build_wide_frame(pif_pkg::DEF_TABLE_ENTRIES, 0);
    frame_keys.push_back(frame_keys[pif_pkg::DEF_TABLE_ENTRIES - 1]);
    frame_keys.push_back(frame_keys[pif_pkg::DEF_TABLE_ENTRIES - 1]);
    send_frame();

    while (pixels_sent < PIXEL_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 15);
      if (kind == 0 && overflow_frames < 2) begin
        overflow_frames++;
        build_wide_frame(pif_pkg::DEF_TABLE_ENTRIES + $urandom_range(1, 8), 4);
      end else begin
        build_pool_frame();
      end
      send_frame();
    end
    no_idle = 1'b0;

    // let the result side catch up completely before the long frame
    push <= 1'b0;
    wait_results_drained();

    // two keys reach the same high count, the smaller one must win
    key_hi = $urandom() | 32'h8000_0000;
    key_lo = $urandom() & 32'h7FFF_FFFF;
    for (int i = 0; i < TIE_RUN; i++) send_pixel(key_hi, 1'b0);
    for (int i = 0; i < TIE_RUN; i++) send_pixel(key_lo, i == TIE_RUN - 1);

    push <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
